// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker of the formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define NXF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define NXF_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/nxf_pkg.sv -----
// Shared types, constants and codes of the eight-tube formatter.
package nxf_pkg;

	localparam int TUBE_COUNT = 8;
	localparam int TUBE_W     = $clog2(TUBE_COUNT);

	// Symbol codes held in the per-tube cache.
	localparam logic [3:0] SYM_LEFT    = 4'd10;
	localparam logic [3:0] SYM_RIGHT   = 4'd11;
	localparam logic [3:0] SYM_EMPTY   = 4'd12;
	localparam logic [3:0] SYM_UNKNOWN = 4'd13;
	localparam logic [3:0] SYM_LAST_DIGIT = 4'd9;

	// Comma code that marks a comma as not fitted.
	localparam logic [4:0] NOT_FITTED = 5'd16;

	localparam int DIGIT_MAP_W = 40;
	localparam int COMMA_W     = 5;

	// Depth of the command queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_TIME      = 3'd0,
		CMD_DATE      = 3'd1,
		CMD_LOCATION  = 3'd2,
		CMD_WR_SYMBOL = 3'd3,
		CMD_WR_DIGIT  = 3'd4,
		CMD_TUBE_OFF  = 3'd5,
		CMD_ALL_OFF   = 3'd6,
		CMD_NONE      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DIGIT_MAP   = 2'd0,
		REG_LEFT_COMMA  = 2'd1,
		REG_RIGHT_COMMA = 2'd2
	} cfg_reg_t;

	// Hemisphere codes.
	localparam logic [1:0] HEMI_UNKNOWN = 2'd0;
	localparam logic [1:0] HEMI_FIRST   = 2'd1;
	localparam logic [1:0] HEMI_SECOND  = 2'd2;

	// Configuration as seen by front and back.
	typedef struct packed {
		logic [DIGIT_MAP_W-1:0] digit_map;
		logic [COMMA_W-1:0]     left_comma_code;
		logic [COMMA_W-1:0]     right_comma_code;
	} cfg_t;

	// Input item as packed in s_tdata, last field in the lowest bits.
	typedef struct packed {
		logic              pad;
		logic [2:0]        tube_select;
		logic [7:0]        number;
		logic [3:0]        symbol;
		logic [1:0]        west_east;
		logic [1:0]        north_south;
		logic signed [8:0] longitude_deg;
		logic signed [7:0] latitude_deg;
		logic [7:0]        second_or_year;
		logic [7:0]        minute_or_month;
		logic [7:0]        hour_or_day;
		logic [2:0]        cmd;
	} in_item_t;

	// Compare records strobe only changed tubes, highest first; force
	// records strobe every selected tube, lowest first.
	typedef enum logic {
		REC_COMPARE = 1'b0,
		REC_FORCE   = 1'b1
	} rec_kind_t;

	typedef struct packed {
		rec_kind_t                       kind;
		logic [TUBE_COUNT-1:0]           sel;
		logic [TUBE_COUNT-1:0][3:0]      sym;
	} rec_t;

	function automatic logic left_fitted(input cfg_t c);
		return c.left_comma_code < NOT_FITTED;
	endfunction

	function automatic logic right_fitted(input cfg_t c);
		return c.right_comma_code < NOT_FITTED;
	endfunction

endpackage

// ----- hw/rtl/nxf_front.sv -----
// Front end: takes commands, formats them into per-tube symbol records.
module nxf_front
	import nxf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  in_item_t item,
	input  logic     q_full,
	output logic     q_push,
	output rec_t     q_rec
);

	typedef struct packed {
		logic [3:0] h;
		logic [3:0] t;
		logic [3:0] o;
	} dec_t;

	// Decimal digits of an 8-bit value: divide by ten with a reciprocal
	// multiply, then split the quotient by compares.
	function automatic dec_t dec3(input logic [7:0] v);
		logic [15:0] p;
		logic [4:0]  q;
		logic [7:0]  rem;
		logic [4:0]  tq;
		dec_t        d;
		p     = 16'(v) * 16'd205;
		q     = p[15:11];
		rem   = v - 8'(q) * 8'd10;
		d.o   = rem[3:0];
		d.h   = (q >= 5'd20) ? 4'd2 : ((q >= 5'd10) ? 4'd1 : 4'd0);
		tq    = q - 5'(d.h) * 5'd10;
		d.t   = tq[3:0];
		return d;
	endfunction

	in_item_t held_q;
	logic     held_vld_q;
	logic     consume;

	cmd_t       cmd;
	logic       lf, rf;
	logic [3:0] err_sym, sep, ns_mark, we_mark, wr_sym;
	logic       err;
	dec_t       da, db, dc, dlat, dlon, dnum;
	logic [TUBE_COUNT-1:0][3:0] s;
	logic [TUBE_COUNT-1:0]      onehot;

	// Holding register for one accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			held_vld_q <= 1'b1;
		end else if (consume) begin
			held_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			held_q <= item;
		end
	end

	assign cmd      = cmd_t'(held_q.cmd);
	assign consume  = held_vld_q && ((cmd == CMD_NONE) || !q_full);
	assign s_tready = !held_vld_q || consume;
	assign q_push   = held_vld_q && (cmd != CMD_NONE) && !q_full;

	// Formatting of the held command into eight symbols.
	always_comb begin
		lf      = left_fitted(cfg);
		rf      = right_fitted(cfg);
		err_sym = rf ? SYM_RIGHT : (lf ? SYM_LEFT : SYM_EMPTY);
		da      = dec3(held_q.hour_or_day);
		db      = dec3(held_q.minute_or_month);
		dc      = dec3(held_q.second_or_year);
		dlat    = dec3(held_q.latitude_deg[7:0]);
		dlon    = dec3(held_q.longitude_deg[7:0]);
		dnum    = dec3(held_q.number);

		// The time separator follows second parity.
		if (!held_q.second_or_year[0]) begin
			sep = lf ? SYM_LEFT : SYM_EMPTY;
		end else begin
			sep = rf ? SYM_RIGHT : SYM_EMPTY;
		end
		if (cmd == CMD_DATE) begin
			sep = err_sym;
		end

		ns_mark = SYM_EMPTY;
		if (held_q.north_south == HEMI_FIRST) begin
			ns_mark = rf ? SYM_RIGHT : SYM_EMPTY;
		end else if (held_q.north_south == HEMI_SECOND) begin
			ns_mark = lf ? SYM_LEFT : SYM_EMPTY;
		end
		we_mark = SYM_EMPTY;
		if (held_q.west_east == HEMI_FIRST) begin
			we_mark = rf ? SYM_RIGHT : SYM_EMPTY;
		end else if (held_q.west_east == HEMI_SECOND) begin
			we_mark = lf ? SYM_LEFT : SYM_EMPTY;
		end

		unique case (cmd)
			CMD_TIME: err = (held_q.hour_or_day > 8'd24) || (held_q.minute_or_month > 8'd60)
				|| (held_q.second_or_year > 8'd60);
			CMD_DATE: err = (held_q.hour_or_day > 8'd31) || (held_q.minute_or_month > 8'd12)
				|| (held_q.second_or_year > 8'd99);
			CMD_LOCATION: err = held_q.latitude_deg[7] || held_q.longitude_deg[8]
				|| (held_q.north_south == HEMI_UNKNOWN) || (held_q.west_east == HEMI_UNKNOWN);
			default: err = 1'b0;
		endcase

		// s[i] is the symbol shown on tube 7 - i.
		if (err) begin
			for (int i = 0; i < TUBE_COUNT; i++) begin
				s[i] = err_sym;
			end
		end else if (cmd == CMD_LOCATION) begin
			s[0] = dlat.t;
			s[1] = dlat.o;
			s[2] = ns_mark;
			s[3] = SYM_EMPTY;
			s[4] = dlon.h;
			s[5] = dlon.t;
			s[6] = dlon.o;
			s[7] = we_mark;
		end else begin
			s[0] = da.t;
			s[1] = da.o;
			s[2] = sep;
			s[3] = db.t;
			s[4] = db.o;
			s[5] = sep;
			s[6] = dc.t;
			s[7] = dc.o;
		end

		wr_sym = (held_q.symbol > SYM_EMPTY) ? SYM_EMPTY : held_q.symbol;
		onehot = '0;
		onehot[held_q.tube_select] = 1'b1;

		// Build the queue record.
		q_rec.kind = REC_COMPARE;
		q_rec.sel  = '1;
		for (int i = 0; i < TUBE_COUNT; i++) begin
			q_rec.sym[TUBE_COUNT-1-i] = s[i];
		end
		unique case (cmd)
			CMD_WR_SYMBOL: begin
				q_rec.sel = onehot;
				q_rec.sym = {TUBE_COUNT{wr_sym}};
			end
			CMD_WR_DIGIT: begin
				q_rec.kind = REC_FORCE;
				q_rec.sel  = onehot;
				q_rec.sym  = {TUBE_COUNT{dnum.o}};
			end
			CMD_TUBE_OFF: begin
				q_rec.kind = REC_FORCE;
				q_rec.sel  = onehot;
				q_rec.sym  = {TUBE_COUNT{SYM_EMPTY}};
			end
			CMD_ALL_OFF: begin
				q_rec.kind = REC_FORCE;
				q_rec.sym  = {TUBE_COUNT{SYM_EMPTY}};
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/nxf_queue.sv -----
// Short command queue between the front end and the strobe engine.
module nxf_queue
	import nxf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output rec_t pop_rec,
	output logic full,
	output logic empty
);

	rec_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	function automatic logic [Q_PTR_W-1:0] next_ptr(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ----- hw/rtl/nxf_back.sv -----
// Strobe engine: walks a record's tubes, keeps the symbol cache, emits strobes.
module nxf_back
	import nxf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_empty,
	input  rec_t       q_rec,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [3:0]            cache_q [TUBE_COUNT];
	logic                  active_q;
	rec_kind_t             kind_q;
	logic [TUBE_COUNT-1:0] mask_q;
	logic [TUBE_COUNT-1:0][3:0] sym_q;
	logic [3:0]            off_q;

	logic                  m_vld_q;
	logic [TUBE_W-1:0]     addr_q;
	logic [3:0]            code_q;
	logic                  last_q;

	logic [TUBE_COUNT-1:0] load_mask, rest_mask;
	logic [TUBE_W-1:0]     hi_idx, lo_idx, pick;
	logic                  emit;
	logic [15:0]           used;
	logic [3:0]            off_d;
	logic [3:0]            pick_sym, code_d;

	// Off code: highest code used by no digit and no fitted comma.
	always_comb begin
		used = '0;
		for (int i = 0; i < 10; i++) begin
			used[cfg.digit_map[4*i +: 4]] = 1'b1;
		end
		if (left_fitted(cfg)) begin
			used[cfg.left_comma_code[3:0]] = 1'b1;
		end
		if (right_fitted(cfg)) begin
			used[cfg.right_comma_code[3:0]] = 1'b1;
		end
		off_d = 4'd15;
		for (int i = 0; i < 16; i++) begin
			if (!used[i]) begin
				off_d = 4'(i);
			end
		end
	end

	// Tube selection for the next strobe.
	always_comb begin
		hi_idx = '0;
		for (int i = 0; i < TUBE_COUNT; i++) begin
			if (mask_q[i]) begin
				hi_idx = TUBE_W'(i);
			end
		end
		lo_idx = '0;
		for (int i = TUBE_COUNT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				lo_idx = TUBE_W'(i);
			end
		end
		pick      = (kind_q == REC_FORCE) ? lo_idx : hi_idx;
		rest_mask = mask_q;
		rest_mask[pick] = 1'b0;
		pick_sym  = sym_q[pick];

		if (pick_sym <= SYM_LAST_DIGIT) begin
			code_d = cfg.digit_map[{pick_sym, 2'b00} +: 4];
		end else if ((pick_sym == SYM_LEFT) && left_fitted(cfg)) begin
			code_d = cfg.left_comma_code[3:0];
		end else if ((pick_sym == SYM_RIGHT) && right_fitted(cfg)) begin
			code_d = cfg.right_comma_code[3:0];
		end else begin
			code_d = off_q;
		end

		// Tubes to strobe for a newly loaded record.
		for (int t = 0; t < TUBE_COUNT; t++) begin
			load_mask[t] = q_rec.sel[t]
				&& ((q_rec.kind == REC_FORCE) || (cache_q[t] != q_rec.sym[t]));
		end
	end

	assign q_pop = !active_q && !q_empty;
	assign emit  = active_q && (!m_vld_q || m_tready);

	// Record walker and symbol cache.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			kind_q   <= REC_COMPARE;
			mask_q   <= '0;
			off_q    <= 4'd15;
			for (int t = 0; t < TUBE_COUNT; t++) begin
				cache_q[t] <= SYM_UNKNOWN;
			end
		end else begin
			off_q <= off_d;
			if (q_pop) begin
				active_q <= (load_mask != '0);
				kind_q   <= q_rec.kind;
				mask_q   <= load_mask;
			end else if (emit) begin
				mask_q         <= rest_mask;
				cache_q[pick]  <= pick_sym;
				if (rest_mask == '0) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sym_q <= q_rec.sym;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (emit) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q <= pick;
			code_q <= code_d;
			last_q <= (rest_mask == '0);
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {1'b0, code_q, addr_q};
	assign m_tlast  = last_q;

endmodule

// ----- hw/rtl/nixie_eight_tube_formatter.sv -----
// Top level of the eight-tube Nixie formatter.
// Each command transaction on the slave stream is held and formatted by the
// front end and queued; the strobe engine loads a command and then emits one
// master-stream transaction per tube latch strobe, one strobe per cycle while
// m_tready does not stall the output. Format commands strobe tube 7 first and
// skip unchanged tubes; all-off strobes tubes 0 to 7. tlast marks a command's
// final strobe. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
module nixie_eight_tube_formatter
	import nxf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [39:0] cfg_wr_data,
	// Command stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[2:0], hour_or_day[10:3], minute_or_month[18:11], second_or_year[26:19],
	// latitude_deg[34:27], longitude_deg[43:35], north_south[45:44],
	// west_east[47:46], symbol[51:48], number[59:52], tube_select[62:60]
	input  logic [63:0] s_tdata,
	// Strobe stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// tube_addr[2:0], cathode_code[6:3]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	cfg_t cfg_q;
	logic q_full, q_empty, q_push, q_pop;
	rec_t push_rec, pop_rec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_map        <= '0;
			cfg_q.left_comma_code  <= NOT_FITTED;
			cfg_q.right_comma_code <= NOT_FITTED;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_DIGIT_MAP:   cfg_q.digit_map        <= cfg_wr_data;
				REG_LEFT_COMMA:  cfg_q.left_comma_code  <= cfg_wr_data[COMMA_W-1:0];
				REG_RIGHT_COMMA: cfg_q.right_comma_code <= cfg_wr_data[COMMA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nxf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item     (in_item_t'(s_tdata)),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (push_rec)
	);

	nxf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.pop      (q_pop),
		.pop_rec  (pop_rec),
		.full     (q_full),
		.empty    (q_empty)
	);

	nxf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_rec    (pop_rec),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- hw/rtl/nxf_checker.sv -----
// Port-level checker of the formatter, bound to the top level.
`include "assert_macros.svh"

module nxf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// A stalled strobe transaction keeps its payload.
	`NXF_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "strobe changed while stalled")

	// The padding bit of the strobe payload stays zero.
	`NXF_ASSERT(a_out_pad, clk, arst_n, m_tvalid |-> !m_tdata[7], "strobe padding bit set")

	// No strobe comes out during reset or in the cycle after it.
	`NXF_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !m_tvalid, "strobe right after reset")

endmodule

bind nixie_eight_tube_formatter nxf_checker u_nxf_checker (.*);

// ----- tb/nxf_strobe_checker.sv -----
// Strobe checker for the eight-tube formatter: predicts tube strobes and compares them.
`timescale 1ns / 100ps

module nxf_strobe_checker
	import nxf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [39:0] cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          strobes_owed
);

	// One latch strobe as the block should emit it.
	typedef struct packed {
		logic [2:0] tube;
		logic [3:0] code;
		logic       last;
	} strobe_t;

	// Shadow of the configuration and of the per-tube symbol cache.
	logic [39:0] map_q;
	logic [4:0]  lcomma_q;
	logic [4:0]  rcomma_q;
	logic [3:0]  tube_cache [TUBE_COUNT];

	// Strobes predicted but not yet seen, oldest first.
	strobe_t strobe_q [$];

	function automatic logic lcomma_on();
		return lcomma_q < NOT_FITTED;
	endfunction

	function automatic logic rcomma_on();
		return rcomma_q < NOT_FITTED;
	endfunction

	function automatic logic [3:0] digit_cathode(input logic [3:0] d);
		return map_q[4*d +: 4];
	endfunction

	// The blank code is the highest code that no digit and no fitted comma uses.
	function automatic logic [3:0] blank_cathode();
		logic [15:0] taken;
		taken = '0;
		for (int i = 0; i < 10; i++)
			taken[map_q[4*i +: 4]] = 1'b1;
		if (lcomma_on())
			taken[lcomma_q[3:0]] = 1'b1;
		if (rcomma_on())
			taken[rcomma_q[3:0]] = 1'b1;
		for (int c = 15; c >= 0; c--)
			if (!taken[c])
				return 4'(c);
		return 4'd15;
	endfunction

	function automatic logic [3:0] cathode_of(input logic [3:0] sym);
		if (sym <= SYM_LAST_DIGIT)
			return digit_cathode(sym);
		if (sym == SYM_LEFT && lcomma_on())
			return lcomma_q[3:0];
		if (sym == SYM_RIGHT && rcomma_on())
			return rcomma_q[3:0];
		return blank_cathode();
	endfunction

	// Symbol used for error fill and for the date separator.
	function automatic logic [3:0] fill_symbol();
		if (rcomma_on())
			return SYM_RIGHT;
		if (lcomma_on())
			return SYM_LEFT;
		return SYM_EMPTY;
	endfunction

	function automatic logic [3:0] comma_or_empty(input logic [3:0] want, input logic fitted);
		return fitted ? want : SYM_EMPTY;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t checker: %s", $time, what);
		fail_count++;
	endtask

	// Work out the strobes that one command causes and update the cache.
	task automatic predict_strobes(input in_item_t it);
		logic [3:0]  glyph [TUBE_COUNT];
		strobe_t     batch [$];
		logic        bad;
		logic [3:0]  sep;
		logic [3:0]  sym;
		logic [2:0]  tube;
		int unsigned a;
		int unsigned b;
		int unsigned c;
		int unsigned lat;
		int unsigned lon;
		a = 32'(it.hour_or_day);
		b = 32'(it.minute_or_month);
		c = 32'(it.second_or_year);
		lat = 32'(it.latitude_deg[6:0]);
		lon = 32'(it.longitude_deg[7:0]);
		tube = it.tube_select;
		case (cmd_t'(it.cmd))
			CMD_TIME, CMD_DATE, CMD_LOCATION: begin
				for (int i = 0; i < TUBE_COUNT; i++)
					glyph[i] = SYM_EMPTY;
				if (cmd_t'(it.cmd) == CMD_TIME)
					bad = a > 24 || b > 60 || c > 60;
				else if (cmd_t'(it.cmd) == CMD_DATE)
					bad = a > 31 || b > 12 || c > 99;
				else
					bad = it.latitude_deg[7] || it.longitude_deg[8] ||
						it.north_south == HEMI_UNKNOWN || it.west_east == HEMI_UNKNOWN;
				if (bad) begin
					for (int i = 0; i < TUBE_COUNT; i++)
						glyph[i] = fill_symbol();
				end else if (cmd_t'(it.cmd) != CMD_LOCATION) begin
					glyph[0] = 4'((a / 10) % 10);
					glyph[1] = 4'(a % 10);
					glyph[3] = 4'((b / 10) % 10);
					glyph[4] = 4'(b % 10);
					glyph[6] = 4'((c / 10) % 10);
					glyph[7] = 4'(c % 10);
					// Time separators blink with the second; date uses the fill comma.
					if (cmd_t'(it.cmd) == CMD_TIME)
						sep = (c % 2 == 0) ? comma_or_empty(SYM_LEFT, lcomma_on())
							: comma_or_empty(SYM_RIGHT, rcomma_on());
					else
						sep = fill_symbol();
					glyph[2] = sep;
					glyph[5] = sep;
				end else begin
					glyph[0] = 4'((lat / 10) % 10);
					glyph[1] = 4'(lat % 10);
					glyph[4] = 4'((lon / 100) % 10);
					glyph[5] = 4'((lon / 10) % 10);
					glyph[6] = 4'(lon % 10);
					// North and east show as the right comma, south and west as the left.
					if (it.north_south == HEMI_FIRST)
						glyph[2] = comma_or_empty(SYM_RIGHT, rcomma_on());
					else if (it.north_south == HEMI_SECOND)
						glyph[2] = comma_or_empty(SYM_LEFT, lcomma_on());
					if (it.west_east == HEMI_FIRST)
						glyph[7] = comma_or_empty(SYM_RIGHT, rcomma_on());
					else if (it.west_east == HEMI_SECOND)
						glyph[7] = comma_or_empty(SYM_LEFT, lcomma_on());
				end
				// Tube 7 gets the first symbol; unchanged tubes are skipped.
				for (int i = 0; i < TUBE_COUNT; i++) begin
					if (tube_cache[7 - i] != glyph[i]) begin
						batch.push_back({3'(7 - i), cathode_of(glyph[i]), 1'b0});
						tube_cache[7 - i] = glyph[i];
					end
				end
			end
			CMD_WR_SYMBOL: begin
				sym = (it.symbol > SYM_EMPTY) ? SYM_EMPTY : it.symbol;
				if (tube_cache[tube] != sym) begin
					batch.push_back({tube, cathode_of(sym), 1'b0});
					tube_cache[tube] = sym;
				end
			end
			CMD_WR_DIGIT: begin
				sym = 4'(it.number % 10);
				batch.push_back({tube, digit_cathode(sym), 1'b0});
				tube_cache[tube] = sym;
			end
			CMD_TUBE_OFF: begin
				batch.push_back({tube, blank_cathode(), 1'b0});
				tube_cache[tube] = SYM_EMPTY;
			end
			CMD_ALL_OFF: begin
				for (int i = 0; i < TUBE_COUNT; i++) begin
					batch.push_back({3'(i), blank_cathode(), 1'b0});
					tube_cache[i] = SYM_EMPTY;
				end
			end
			default: begin
			end
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			strobe_q.push_back(batch[i]);
	endtask

	// Register writes, then strobes against older predictions, then new commands.
	always @(posedge clk or negedge arst_n) begin
		strobe_t want;
		if (!arst_n) begin
			map_q = '0;
			lcomma_q = NOT_FITTED;
			rcomma_q = NOT_FITTED;
			for (int i = 0; i < TUBE_COUNT; i++)
				tube_cache[i] = SYM_UNKNOWN;
			strobe_q.delete();
			fail_count = 0;
			strobes_owed <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_addr))
					REG_DIGIT_MAP:   map_q = cfg_wr_data;
					REG_LEFT_COMMA:  lcomma_q = cfg_wr_data[4:0];
					REG_RIGHT_COMMA: rcomma_q = cfg_wr_data[4:0];
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (strobe_q.size() == 0) begin
					report_mismatch($sformatf("unexpected strobe tube %0d code %0d last %0b",
						m_tdata[2:0], m_tdata[6:3], m_tlast));
				end else begin
					want = strobe_q.pop_front();
					if (m_tdata[2:0] != want.tube)
						report_mismatch($sformatf("tube_addr %0d, expected %0d",
							m_tdata[2:0], want.tube));
					if (m_tdata[6:3] != want.code)
						report_mismatch($sformatf("cathode_code %0d on tube %0d, expected %0d",
							m_tdata[6:3], want.tube, want.code));
					if (m_tlast != want.last)
						report_mismatch($sformatf("tlast %0b on tube %0d, expected %0b",
							m_tlast, want.tube, want.last));
				end
			end
			if (s_tvalid && s_tready)
				predict_strobes(in_item_t'(s_tdata));
			strobes_owed <= strobe_q.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the eight-tube formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
	import nxf_pkg::*;

	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_addr;
	logic [39:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	// cmd, hour_or_day, minute_or_month, second_or_year, latitude_deg,
	// longitude_deg, north_south, west_east, symbol, number, tube_select
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// tube_addr, cathode_code
	logic [7:0]  m_tdata;
	logic        m_tlast;

	int fail_count;
	int strobes_owed;
	int quiet_cycles;

	// Pacing controls of the sender and the receiver.
	logic tx_steady;
	logic rx_steady;
	logic hold_on;

	nixie_eight_tube_formatter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	nxf_strobe_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wr_data  (cfg_wr_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.strobes_owed (strobes_owed)
	);

	// 2 ns clock.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// End the run when nothing has been accepted on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Strobe receiver: random stalls, steady stretches and one long hold-off.
	initial begin : strobe_sink
		int stall;
		int r;
		logic hold_seen;
		stall = 0;
		hold_seen = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_on && !hold_seen)
				stall = HOLD_CYCLES;
			hold_seen = hold_on;
			if (stall == 0 && !rx_steady) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					stall = $urandom_range(10, 40);
				else if (r < 30)
					stall = $urandom_range(1, 3);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one command transaction after a random gap and wait for its acceptance.
	task automatic send(input in_item_t it);
		int gap;
		int r;
		gap = 0;
		if (!tx_steady) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(10, 40);
			else if (r >= 50)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Write all three registers; only called while the block is idle.
	task automatic program_regs(input logic [39:0] map, input logic [4:0] lc,
		input logic [4:0] rc);
		cfg_wr_en <= 1'b1;
		cfg_addr <= REG_DIGIT_MAP;
		cfg_wr_data <= map;
		@(posedge clk);
		cfg_addr <= REG_LEFT_COMMA;
		cfg_wr_data <= {35'd0, lc};
		@(posedge clk);
		cfg_addr <= REG_RIGHT_COMMA;
		cfg_wr_data <= {35'd0, rc};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stop offering, wait for every predicted strobe, then let commands with no
	// strobes drain out of the queue.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (strobes_owed == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_item_t clock_item(input cmd_t op, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c);
		in_item_t it;
		it = '0;
		it.cmd = op;
		it.hour_or_day = a;
		it.minute_or_month = b;
		it.second_or_year = c;
		return it;
	endfunction

	function automatic in_item_t place_item(input logic [7:0] lat, input logic [8:0] lon,
		input logic [1:0] ns, input logic [1:0] we);
		in_item_t it;
		it = '0;
		it.cmd = CMD_LOCATION;
		it.latitude_deg = lat;
		it.longitude_deg = lon;
		it.north_south = ns;
		it.west_east = we;
		return it;
	endfunction

	function automatic in_item_t tube_item(input cmd_t op, input logic [3:0] sym,
		input logic [7:0] num, input logic [2:0] tube);
		in_item_t it;
		it = '0;
		it.cmd = op;
		it.symbol = sym;
		it.number = num;
		it.tube_select = tube;
		return it;
	endfunction

	// Random commands: mostly well-formed format commands, some out of range,
	// plus tube writes, blanking and the unused command.
	task automatic run_random(input int count);
		in_item_t it;
		int r;
		logic sane;
		for (int k = 0; k < count; k++) begin
			if (k % 10 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			it = in_item_t'({$urandom, $urandom});
			it.pad = 1'b0;
			sane = ($urandom_range(0, 9) != 0);
			r = $urandom_range(0, 99);
			if (r < 25) begin
				it.cmd = CMD_TIME;
				if (sane) begin
					it.hour_or_day = 8'($urandom_range(0, 24));
					it.minute_or_month = 8'($urandom_range(0, 60));
					it.second_or_year = 8'($urandom_range(0, 60));
				end
			end else if (r < 45) begin
				it.cmd = CMD_DATE;
				if (sane) begin
					it.hour_or_day = 8'($urandom_range(0, 31));
					it.minute_or_month = 8'($urandom_range(0, 12));
					it.second_or_year = 8'($urandom_range(0, 99));
				end
			end else if (r < 62) begin
				it.cmd = CMD_LOCATION;
				if (sane) begin
					it.latitude_deg = 8'($urandom_range(0, 127));
					it.longitude_deg = 9'($urandom_range(0, 255));
					it.north_south = 2'($urandom_range(1, 3));
					it.west_east = 2'($urandom_range(1, 3));
				end
			end else if (r < 75) begin
				it.cmd = CMD_WR_SYMBOL;
			end else if (r < 85) begin
				it.cmd = CMD_WR_DIGIT;
			end else if (r < 91) begin
				it.cmd = CMD_TUBE_OFF;
			end else if (r < 96) begin
				it.cmd = CMD_ALL_OFF;
			end else begin
				it.cmd = CMD_NONE;
			end
			send(it);
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= REG_DIGIT_MAP;
		cfg_wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_on = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain digit table with both commas fitted.
		program_regs(40'h98_7654_3210, 5'd10, 5'd11);

		// Time: full write from unknown cache, separator blink, no change,
		// upper bounds, errors.
		send(clock_item(CMD_TIME, 8'd23, 8'd59, 8'd58));
		send(clock_item(CMD_TIME, 8'd23, 8'd59, 8'd59));
		send(clock_item(CMD_TIME, 8'd23, 8'd59, 8'd59));
		send(clock_item(CMD_TIME, 8'd24, 8'd60, 8'd60));
		send(clock_item(CMD_TIME, 8'd25, 8'd0, 8'd0));
		send(clock_item(CMD_TIME, 8'd255, 8'd255, 8'd255));
		// Date: bounds and an out-of-range month.
		send(clock_item(CMD_DATE, 8'd31, 8'd12, 8'd99));
		send(clock_item(CMD_DATE, 8'd0, 8'd0, 8'd0));
		send(clock_item(CMD_DATE, 8'd32, 8'd13, 8'd100));
		// Location: extremes, both hemispheres, code three, invalid values.
		send(place_item(8'd127, 9'd255, HEMI_FIRST, HEMI_FIRST));
		send(place_item(8'd0, 9'd0, HEMI_SECOND, HEMI_SECOND));
		send(place_item(8'd45, 9'd123, 2'd3, 2'd3));
		send(place_item(8'h80, 9'd100, HEMI_FIRST, HEMI_FIRST));
		send(place_item(8'd10, 9'h100, HEMI_FIRST, HEMI_FIRST));
		send(place_item(8'd10, 9'd10, HEMI_UNKNOWN, HEMI_SECOND));
		// Single-tube writes: digits, commas, a symbol above twelve, no change.
		send(tube_item(CMD_WR_SYMBOL, 4'd0, 8'd0, 3'd0));
		send(tube_item(CMD_WR_SYMBOL, 4'd9, 8'd0, 3'd7));
		send(tube_item(CMD_WR_SYMBOL, SYM_LEFT, 8'd0, 3'd3));
		send(tube_item(CMD_WR_SYMBOL, SYM_RIGHT, 8'd0, 3'd3));
		send(tube_item(CMD_WR_SYMBOL, 4'd15, 8'd0, 3'd3));
		send(tube_item(CMD_WR_SYMBOL, SYM_EMPTY, 8'd0, 3'd3));
		send(tube_item(CMD_WR_DIGIT, 4'd0, 8'd255, 3'd5));
		send(tube_item(CMD_WR_DIGIT, 4'd0, 8'd0, 3'd5));
		send(tube_item(CMD_TUBE_OFF, 4'd0, 8'd0, 3'd2));
		send(tube_item(CMD_ALL_OFF, 4'd0, 8'd0, 3'd0));
		send(tube_item(CMD_NONE, 4'd15, 8'd255, 3'd7));
		settle();

		// Random phases, each under its own table and comma setting.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: program_regs(40'h01_2345_6789, 5'd0, 5'd12);
				1: program_regs(40'hFF_FFFF_FFFF, NOT_FITTED, 5'd31);
				2: program_regs(40'h00_0000_0000, 5'd0, NOT_FITTED);
				default: program_regs(40'({$urandom, $urandom}),
					5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)));
			endcase
			rx_steady = (phase == 2);
			// The receiver holds off in the first phase while commands keep coming.
			hold_on = (phase == 0);
			run_random(20);
			hold_on = 1'b0;
			settle();
		end

		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
